### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check on the rising clock edge, live during reset as well
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/asa_pkg.sv
package asa_pkg;

    // default sizing
    localparam int ASA_MAX_BLOCKS   = 64;
    localparam int ASA_HEADER_BYTES = 8;

    // payload widths
    localparam int ADDR_W     = 32;
    localparam int FUNC_W     = 2;
    localparam int ALIGN_W    = 7;
    localparam int STATUS_W   = 3;
    localparam int LIVE_W     = 7;
    localparam int PAD_W      = 8;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;
    localparam int CFG_IDX_W  = 1;

    // request kinds
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ALIGN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_TOP   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the request on its transfer
        logic prep;      // read stack top, precompute address and padding
        logic commit;    // update state and load the result register
    } asa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or draining this cycle
    } asa_stat_t;

endpackage

### design/asa_ctrl.sv
module asa_ctrl
    import asa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  asa_stat_t stat,
    output asa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_EXEC;
            S_EXEC: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.prep    = (state_reg == S_READ);
    assign cmd.commit  = (state_reg == S_EXEC) && stat.out_free;

endmodule

### design/asa_datapath.sv
module asa_datapath
    import asa_pkg::*;
#(
    parameter int MAX_BLOCKS   = ASA_MAX_BLOCKS,
    parameter int HEADER_BYTES = ASA_HEADER_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  asa_cmd_t             cmd,
    output asa_stat_t            stat,
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENT_W = PAD_W + ADDR_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [PAD_W-1:0] HDR     = PAD_W'(HEADER_BYTES);

    // configuration
    logic [ADDR_W-1:0] base_reg, size_reg;

    // allocator state
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [ADDR_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // latched request
    logic [FUNC_W-1:0]  func_reg;
    logic [ADDR_W-1:0]  req_reg;
    logic [ALIGN_W-1:0] al_reg;
    logic [ADDR_W-1:0]  faddr_reg;

    // precomputed values and stack top
    logic [ADDR_W-1:0] addr_reg;
    logic [PAD_W-1:0]  adj_reg;
    logic [ENT_W-1:0]  rd_reg;

    // stack of padding and granted address per live block
    logic [ENT_W-1:0] stack_mem [MAX_BLOCKS];

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [ADDR_W-1:0]   addr_now;
    logic [ALIGN_W-1:0]  mask;
    logic [ALIGN_W-1:0]  adj0;
    logic [PAD_W-1:0]    need_up;
    logic [PAD_W-1:0]    adj_now;
    logic [CNT_W-1:0]    cnt_dec;
    logic [ADDR_W+1:0]   total;
    logic                bad_align;
    logic                wr_en;
    logic [ADDR_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   pad32;
    logic [ADDR_W-1:0]   adj32;
    logic [ADDR_W-1:0]   boff;
    logic [CNT_W+LIVE_W-1:0] cnt_wide;

    // config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            size_reg <= 32'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_REGION_BASE: base_reg <= cfg_data;
                REG_REGION_SIZE: size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_tuser;
            req_reg   <= s_tdata[31:0];
            al_reg    <= s_tdata[38:32];
            faddr_reg <= s_tdata[70:39];
        end
    end

    // padding: forward adjust to the alignment, then whole steps until the header fits
    always_comb begin
        addr_now = base_reg + top_reg;
        mask     = al_reg - 1'b1;
        adj0     = (al_reg - (addr_now[ALIGN_W-1:0] & mask)) & mask;
        need_up  = (HDR - {1'b0, adj0}) + {1'b0, mask};
        if ({1'b0, adj0} < HDR) begin
            adj_now = {1'b0, adj0} + (need_up & ~{1'b0, mask});
        end else begin
            adj_now = {1'b0, adj0};
        end
    end

    // stack top read and precompute
    assign cnt_dec = cnt_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            addr_reg <= addr_now;
            adj_reg  <= adj_now;
            rd_reg   <= stack_mem[cnt_dec[IDX_W-1:0]];
        end
    end

    // request execution
    always_comb begin
        bad_align = (al_reg == '0) || ((al_reg & (al_reg - 1'b1)) != '0);
        adj32     = {{(ADDR_W-PAD_W){1'b0}}, adj_reg};
        pad32     = {{(ADDR_W-PAD_W){1'b0}}, rd_reg[ENT_W-1:ADDR_W]};
        boff      = faddr_reg - base_reg;
        total     = {2'b00, used_reg} + {2'b00, adj32} + {2'b00, req_reg};
        granted   = '0;
        status    = ST_OK;
        wr_en     = 1'b0;
        top_next  = top_reg;
        used_next = used_reg;
        cnt_next  = cnt_reg;
        unique case (func_reg)
            FUNC_ALLOC: begin
                priority if (req_reg == '0) begin
                    status = ST_ZERO_SIZE;
                end else if (bad_align) begin
                    status = ST_BAD_ALIGN;
                end else if (cnt_reg >= CNT_MAX) begin
                    status = ST_FULL;
                end else if (total > {2'b00, size_reg}) begin
                    status = ST_NO_SPACE;
                end else begin
                    granted   = addr_reg + adj32;
                    wr_en     = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    top_next  = top_reg + adj32 + req_reg;
                    used_next = used_reg + adj32 + req_reg;
                end
            end
            FUNC_FREE: begin
                priority if (cnt_reg == '0) begin
                    status = ST_EMPTY;
                end else if (faddr_reg != rd_reg[ADDR_W-1:0]) begin
                    status = ST_NOT_TOP;
                end else begin
                    used_next = used_reg - ((top_reg - boff) + pad32);
                    top_next  = boff - pad32;
                    cnt_next  = cnt_dec;
                end
            end
            FUNC_CLEAR: begin
                top_next  = '0;
                used_next = '0;
                cnt_next  = '0;
            end
            default: ;
        endcase
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg  <= '0;
            used_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.commit) begin
            top_reg  <= top_next;
            used_reg <= used_next;
            cnt_reg  <= cnt_next;
        end
    end

    // stack push
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            stack_mem[cnt_reg[IDX_W-1:0]] <= {adj_reg, granted};
        end
    end

    // result register
    assign cnt_wide = {{LIVE_W{1'b0}}, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {6'b0, cnt_wide[LIVE_W-1:0], used_next, status, granted};
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

### design/aligned_stack_allocator.sv
// Aligned stack allocator: a LIFO bump allocator over the region set by
// region_base and region_size. A request on the slave stream allocates
// (tuser 0), frees the top block (tuser 1) or clears everything (tuser 2),
// and every request answers with exactly one result transfer carrying the
// granted address, a status code and the current byte and block counts.
// After its request transfer, the read state does the registered read of
// the stack top and the address and padding precompute, then the execute
// state updates state and loads the result register. The execute state
// waits while the result register is still held by a stalled master. A
// new request is taken only in idle, once the last one has been executed.
// The next request is taken while a result waits.
// Configuration writes are taken at any time and must only come while no
// request is in flight.
module aligned_stack_allocator
    import asa_pkg::*;
#(
    parameter int MAX_BLOCKS   = ASA_MAX_BLOCKS,
    parameter int HEADER_BYTES = ASA_HEADER_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_bytes[31:0], align_bytes[38:32],
                                            // free_address[70:39], zero[71]
    input  logic [FUNC_W-1:0]    s_tuser,   // func[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // block_address[31:0], status[34:32],
                                            // bytes_in_use[66:35], live_blocks[73:67],
                                            // zero[79:74]
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    asa_cmd_t  cmd;
    asa_stat_t stat;

    // sequencer
    asa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic, stack and result register
    asa_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### design/asa_checker.sv
`include "assert_macros.svh"

module asa_checker
    import asa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // no result right after reset
    `ASSERT_CLK_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // status code stays within the defined set
    `ASSERT_CLK(a_status_range, m_tvalid |-> m_tdata[34:32] <= ST_NOT_TOP, "undefined status code")

    // a failed request carries a zero address
    `ASSERT_CLK(a_addr_on_error, m_tvalid && m_tdata[34:32] != ST_OK |-> m_tdata[31:0] == '0, "address on failed request")

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
